[hw/rtl/assert_macros.svh]
// Assertion helpers used by the pip_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a signal is low from the edge after reset is seen low
`define ASSERT_RST_LOW(label, sig, msg) \
  label: assert property (@(posedge clk_i) !rst_ni |=> !(sig)) else $error(msg);

`endif

[hw/rtl/pip_pkg.sv]
package pip_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  // Fixed field widths
  localparam int unsigned CNT_W = 7;
  localparam int unsigned IDX_W = 6;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Query sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } pip_state_e;

  // Control travelling alongside the vertex read data
  typedef struct packed {
    logic start;  // clear the parity flag for a new query
    logic vld;    // read data valid this cycle
    logic first;  // seed read: last vertex in use, opens the first edge
    logic last;   // final vertex of the walk
  } pip_ctl_t;

endpackage

[hw/rtl/pip_ram.sv]
module pip_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pip_edge.sv]
module pip_edge #(
  parameter int unsigned CoordWidth = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pip_pkg::pip_ctl_t            ctl_i,
  input  logic [2*CoordWidth-1:0]      rd_data_i,
  input  logic signed [CoordWidth-1:0] px_i,
  input  logic signed [CoordWidth-1:0] py_i,
  output logic                         done_o,
  output logic                         inside_o
);
  import pip_pkg::*;

  localparam int unsigned DW = CoordWidth + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [CoordWidth-1:0] cur_x, cur_y;
  logic signed [CoordWidth-1:0] prev_x_q, prev_y_q;

  logic                 s1_vld_q, s1_last_q, s1_cross_q;
  logic signed [DW-1:0] s1_a_q, s1_dy_q, s1_b_q, s1_c_q;
  logic                 s1_cross_d;

  logic                 s2_vld_q, s2_last_q, s2_cross_q, s2_dpos_q;
  logic signed [PW-1:0] s2_p1_q, s2_p2_q;

  logic done_q, inside_q, toggle;

  // RAM word is {x, y}
  assign cur_x = rd_data_i[2*CoordWidth-1:CoordWidth];
  assign cur_y = rd_data_i[CoordWidth-1:0];

  // Edge straddles the ray when its ends sit on opposite sides of py
  assign s1_cross_d = (cur_y > py_i) != (prev_y_q > py_i);

  // Previous vertex: current vertex is (x1,y1), previous is (x2,y2)
  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
  end

  // Stage 1: differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= ctl_i.vld & ~ctl_i.first;
      s1_last_q <= ctl_i.vld & ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      s1_cross_q <= s1_cross_d;
      s1_a_q     <= DW'(px_i) - DW'(cur_x);
      s1_dy_q    <= DW'(prev_y_q) - DW'(cur_y);
      s1_b_q     <= DW'(prev_x_q) - DW'(cur_x);
      s1_c_q     <= DW'(py_i) - DW'(cur_y);
    end
  end

  // Stage 2: the two cross products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_cross_q <= s1_cross_q;
      s2_dpos_q  <= ~s1_dy_q[DW-1];
      s2_p1_q    <= PW'(s1_a_q) * PW'(s1_dy_q);
      s2_p2_q    <= PW'(s1_b_q) * PW'(s1_c_q);
    end
  end

  // Stage 3: point strictly right of the crossing flips parity.
  // Multiplying through by dy reverses the sense when dy is negative.
  assign toggle = s2_vld_q & s2_cross_q &
                  (s2_dpos_q ? (s2_p1_q > s2_p2_q) : (s2_p1_q < s2_p2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= s2_vld_q & s2_last_q;
      if (ctl_i.start) begin
        inside_q <= 1'b0;
      end else if (toggle) begin
        inside_q <= ~inside_q;
      end
    end
  end

  assign done_o   = done_q;
  assign inside_o = inside_q;

endmodule

[hw/rtl/point_in_polygon_test.sv]
// Channel | Direction | Handshake              | Payload
// in      | in        | in_valid_i / in_stall_o | kind_i, vertex_index_i, coord_x_i, coord_y_i
// out     | out       | out_valid_o / out_stall_i | inside_res_o
// cfg     | in        | cfg_valid_i / cfg_ready_o | vertex_count_i
//
// A vertex load is written straight into the vertex RAM.
// A query with n vertices in use (n >= 3) makes n + 1 reads of the single RAM
// read port (last vertex first, then 0 .. n-1), one edge per cycle, and then
// passes the three-stage crossing pipeline and the result hand-off.
// Fewer than three vertices answer outside without a walk.
// Reset clears the sequencer, the count register and the result slot; RAM
// contents are undefined until loaded. A stalled result holds in its register
// while further loads are still taken.
module point_in_polygon_test #(
  parameter int unsigned MaxVertices = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned CoordWidth  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [pip_pkg::IDX_W-1:0]    vertex_index_i,
  input  logic signed [CoordWidth-1:0] coord_x_i,
  input  logic signed [CoordWidth-1:0] coord_y_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pip_pkg::CNT_W-1:0]    vertex_count_i
);
  import pip_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned NW = $clog2(MaxVertices + 1);

  pip_state_e state_q, state_d;

  logic [CNT_W-1:0]             count_q;
  logic [NW-1:0]                n_q, n_d, n_sat, n_m1, k_q, k_d, k_m1;
  logic signed [CoordWidth-1:0] px_q, py_q;
  logic                         res_q, res_d;
  logic                         out_vld_q, out_vld_d, out_res_q, out_res_d;
  pip_ctl_t                     ctl_q, ctl_d;

  logic                         in_acc, slot_ok, wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [2*CoordWidth-1:0]      rd_data;
  logic                         edge_done, edge_inside;

  // Configuration transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= vertex_count_i;
    end
  end

  // Count saturates at the table depth
  assign n_sat = (32'(count_q) > 32'(MaxVertices)) ? NW'(MaxVertices) : NW'(count_q);
  assign n_m1  = n_q - 1'b1;
  assign k_m1  = k_q - 1'b1;

  // Input transfer; loads only happen in idle so they never meet a walk
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign slot_ok    = 32'(vertex_index_i) < 32'(MaxVertices);
  assign wr_en      = in_acc & (kind_i == KIND_LOAD) & slot_ok;
  assign wr_addr    = AW'(vertex_index_i);

  // Query sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    res_d     = res_q;
    out_vld_d = out_vld_q & out_stall_i;
    out_res_d = out_res_q;
    rd_en     = 1'b0;
    rd_addr   = k_m1[AW-1:0];
    ctl_d     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_i == KIND_QUERY)) begin
          n_d         = n_sat;
          k_d         = '0;
          res_d       = 1'b0;
          ctl_d.start = 1'b1;
          if (n_sat < NW'(3)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_en       = 1'b1;
        rd_addr     = (k_q == '0) ? n_m1[AW-1:0] : k_m1[AW-1:0];
        ctl_d.vld   = 1'b1;
        ctl_d.first = (k_q == '0);
        ctl_d.last  = (k_q == n_q);
        k_d         = k_q + 1'b1;
        if (k_q == n_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (edge_done) begin
          res_d   = edge_inside;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_res_d = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      ctl_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      ctl_q     <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
    if (in_acc) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign inside_res_o = out_res_q;

  // Vertex memory, {x, y} per entry
  pip_ram #(
    .Width (2 * CoordWidth),
    .Depth (MaxVertices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Edge crossing pipeline
  pip_edge #(
    .CoordWidth (CoordWidth)
  ) u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_q),
    .rd_data_i (rd_data),
    .px_i      (px_q),
    .py_i      (py_q),
    .done_o    (edge_done),
    .inside_o  (edge_inside)
  );

endmodule

[hw/rtl/pip_chk.sv]
`include "assert_macros.svh"

module pip_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic kind_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic inside_res_o
);
  import pip_pkg::*;

  // A pending result is not dropped while stalled
  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // Stalled result keeps its value
  `ASSERT_CLK(a_out_stable, out_valid_o && out_stall_i |=> $stable(inside_res_o), "result changed under stall")

  // A query transfer closes the input
  `ASSERT_CLK(a_query_busy, in_valid_i && !in_stall_o && kind_i == KIND_QUERY |=> in_stall_o, "input open after query")

  // A vertex load never produces a result
  `ASSERT_CLK(a_load_silent, in_valid_i && !in_stall_o && kind_i == KIND_LOAD && !out_valid_o |=> !out_valid_o, "result from a load")

  // No result while reset is held
  `ASSERT_RST_LOW(a_rst_out, out_valid_o, "result valid in reset")

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (.*);
